[hw/rtl/ate_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// shared types and constants of the tilt / ema filter
// no dependencies
package ate_pkg;

    localparam int DEF_CORDIC_STEPS = 16;
    localparam int MAX_CORDIC_STEPS = 24;
    localparam int XY_W             = 33;
    localparam int ANG_W            = 25;
    localparam int ANGLE_LIMIT      = 23040;
    localparam int HALF_TURN_FINE   = 5898240;
    localparam logic [16:0] GAIN_ONE   = 17'd65536;
    localparam logic [16:0] GAIN_RESET = 17'd6554;

    localparam logic [1:0] CMD_SAMPLE  = 2'd0;
    localparam logic [1:0] CMD_CAPTURE = 2'd1;
    localparam logic [1:0] CMD_CLEAR   = 2'd2;
    localparam logic [1:0] CMD_LOAD    = 2'd3;

    localparam logic [2:0] ADDR_GAIN = 3'd0;

    // arctangent of 2^-i in 1/32768 degree, rounded
    localparam logic [23:0] ATAN_TABLE [MAX_CORDIC_STEPS] = '{
        24'd1474560, 24'd870484, 24'd459940, 24'd233473, 24'd117189, 24'd58652,
        24'd29333, 24'd14667, 24'd7334, 24'd3667, 24'd1833, 24'd917,
        24'd458, 24'd229, 24'd115, 24'd57, 24'd29, 24'd14,
        24'd7, 24'd4, 24'd2, 24'd1, 24'd0, 24'd0
    };

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] ang;
    } cordic_t;

    typedef struct packed {
        logic load;
        logic mul;
        logic commit;
        logic update;
    } ema_ctl_t;

endpackage
`default_nettype wire

[hw/rtl/accel_tilt_ema_filter_core.sv]
`timescale 1ns / 1ps
// a word passes the input registers, the row of cordic cells, the tilt registers,
// then the ema difference, product and average registers to result valid
// one word in flight: next word taken once the result word has been taken
// the tilt path is the row of cordic cells, one iteration per cell
// reset (rst_n, async, active low) clears averages, offsets, gain to 6554
`default_nettype none
module accel_tilt_ema_filter_core
    import ate_pkg::*;
#(
    parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // accel_x, accel_y, accel_z, zero_front_back, zero_sideways
    input  wire logic [79:0] s_tdata,
    // command
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // smooth_accel_x, smooth_accel_y, smooth_accel_z, smooth_tilt_side,
    // smooth_tilt_front, zero pad
    output logic [87:0]      m_tdata
);

    localparam int TOK_W = CORDIC_STEPS + 4;

    logic [16:0]        gain_reg;
    logic [16:0]        gain_eff;
    logic               busy_reg;
    logic               m_valid_reg;
    logic [TOK_W-1:0]   tok_reg;
    logic [TOK_W-1:0]   tok_next;
    logic [1:0]         cmd_reg;
    logic signed [15:0] ax_reg, ay_reg, az_reg, zf_reg, zs_reg;
    logic signed [15:0] side_reg, front_reg;
    logic signed [15:0] side_next, front_next;
    logic signed [15:0] off_side_reg, off_front_reg;
    logic               in_acc;
    logic               out_acc;
    ema_ctl_t           ctl;

    cordic_t side_c  [CORDIC_STEPS+1];
    cordic_t front_c [CORDIC_STEPS+1];

    logic signed [15:0] sx, sy, sz;
    logic signed [16:0] st_side, st_front;

    // register write / read
    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_GAIN) ? {15'h0000, gain_reg} : 32'h0000_0000;
    assign gain_eff = (gain_reg > GAIN_ONE) ? GAIN_ONE : gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (psel && penable && pwrite && (paddr == ADDR_GAIN))
        begin
            gain_reg <= pwdata[16:0];
        end
    end

    assign s_tready = !busy_reg;
    assign m_tvalid = m_valid_reg;
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_valid_reg && m_tready;
    assign tok_next = {tok_reg[TOK_W-2:0], in_acc};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            tok_reg     <= '0;
        end
        else
        begin
            tok_reg <= tok_next;
            if (in_acc)
            begin
                busy_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                busy_reg <= 1'b0;
            end
            if (tok_reg[TOK_W-1])
            begin
                m_valid_reg <= 1'b1;
            end
            else if (out_acc)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // input word held for the whole item
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cmd_reg <= s_tuser;
            ax_reg  <= s_tdata[15:0];
            ay_reg  <= s_tdata[31:16];
            az_reg  <= s_tdata[47:32];
            zf_reg  <= s_tdata[63:48];
            zs_reg  <= s_tdata[79:64];
        end
    end

    function automatic cordic_t cordic_seed(input logic signed [15:0] num,
                                            input logic signed [15:0] den);
        cordic_t c;
        c.x   = $signed({{(XY_W-30){den[15]}}, den, 14'h0000});
        c.y   = $signed({{(XY_W-30){num[15]}}, num, 14'h0000});
        c.ang = '0;
        if (den[15])
        begin
            c.x   = -c.x;
            c.y   = -c.y;
            c.ang = num[15] ? -ANG_W'(HALF_TURN_FINE) : ANG_W'(HALF_TURN_FINE);
        end
        return c;
    endfunction

    function automatic logic signed [15:0] tilt_final(input logic signed [15:0] num,
                                                      input logic signed [15:0] den,
                                                      input logic signed [ANG_W-1:0] ang);
        logic signed [ANG_W-1:0] r;
        logic signed [16:0]      q;
        logic signed [15:0]      t;
        r = ang + ANG_W'(128);
        q = 17'(r >>> 8);
        if (q > 17'(ANGLE_LIMIT))
        begin
            t = 16'(ANGLE_LIMIT);
        end
        else if (q < -17'(ANGLE_LIMIT))
        begin
            t = -16'(ANGLE_LIMIT);
        end
        else
        begin
            t = q[15:0];
        end
        if (num == '0)
        begin
            t = den[15] ? 16'(ANGLE_LIMIT) : 16'sd0;
        end
        return t;
    endfunction

    assign side_c[0]  = cordic_seed(ay_reg, az_reg);
    assign front_c[0] = cordic_seed(ax_reg, az_reg);

    for (genvar k = 0; k < CORDIC_STEPS; k++)
    begin : g_row
        ate_cordic_cell #(.STEP(k)) u_side
        (
            .clk  (clk),
            .cin  (side_c[k]),
            .cout (side_c[k+1])
        );
        ate_cordic_cell #(.STEP(k)) u_front
        (
            .clk  (clk),
            .cin  (front_c[k]),
            .cout (front_c[k+1])
        );
    end

    assign side_next  = tilt_final(ay_reg, az_reg, side_c[CORDIC_STEPS].ang);
    assign front_next = tilt_final(ax_reg, az_reg, front_c[CORDIC_STEPS].ang);

    always_ff @(posedge clk)
    begin
        if (tok_reg[CORDIC_STEPS])
        begin
            side_reg  <= side_next;
            front_reg <= front_next;
        end
    end

    function automatic logic signed [15:0] zero_clamp(input logic signed [15:0] v);
        if (v > 16'(ANGLE_LIMIT))
        begin
            return 16'(ANGLE_LIMIT);
        end
        else if (v < -16'(ANGLE_LIMIT))
        begin
            return -16'(ANGLE_LIMIT);
        end
        return v;
    endfunction

    // offsets change on the same edge the ema lanes take their difference
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_side_reg  <= '0;
            off_front_reg <= '0;
        end
        else if (tok_reg[CORDIC_STEPS+1])
        begin
            unique case (cmd_reg)
                CMD_CAPTURE:
                begin
                    off_side_reg  <= side_reg;
                    off_front_reg <= front_reg;
                end
                CMD_CLEAR:
                begin
                    off_side_reg  <= '0;
                    off_front_reg <= '0;
                end
                CMD_LOAD:
                begin
                    off_side_reg  <= zero_clamp(zs_reg);
                    off_front_reg <= zero_clamp(zf_reg);
                end
                default:
                begin
                    off_side_reg  <= off_side_reg;
                    off_front_reg <= off_front_reg;
                end
            endcase
        end
    end

    assign ctl.load   = tok_reg[CORDIC_STEPS+1];
    assign ctl.mul    = tok_reg[CORDIC_STEPS+2];
    assign ctl.commit = tok_reg[CORDIC_STEPS+3];
    assign ctl.update = (cmd_reg == CMD_SAMPLE);

    ate_ema_lane #(.AVG_W(32)) u_ema_x
    (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(ax_reg),
        .gain(gain_eff), .smooth(sx)
    );
    ate_ema_lane #(.AVG_W(32)) u_ema_y
    (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(ay_reg),
        .gain(gain_eff), .smooth(sy)
    );
    ate_ema_lane #(.AVG_W(32)) u_ema_z
    (
        .clk(clk), .rst_n(rst_n), .ctl(ctl), .sample(az_reg),
        .gain(gain_eff), .smooth(sz)
    );
    ate_ema_lane #(.AVG_W(33)) u_ema_side
    (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .sample(17'({side_reg[15], side_reg}) - 17'({off_side_reg[15], off_side_reg})),
        .gain(gain_eff), .smooth(st_side)
    );
    ate_ema_lane #(.AVG_W(33)) u_ema_front
    (
        .clk(clk), .rst_n(rst_n), .ctl(ctl),
        .sample(17'({front_reg[15], front_reg}) - 17'({off_front_reg[15], off_front_reg})),
        .gain(gain_eff), .smooth(st_front)
    );

    assign m_tdata = {6'b000000, st_front, st_side, sz, sy, sx};

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> (tok_reg == '0 && !m_valid_reg))
        else $error("ready while an item is in flight");
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(tok_reg))
        else $error("more than one item in the cell row");
    a_done_valid: assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg[TOK_W-1] |=> m_valid_reg)
        else $error("commit without result valid");
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc |=> !s_tready)
        else $error("ready stayed high after accept");
`endif

endmodule
`default_nettype wire

[hw/rtl/ate_cordic_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// one vectoring cordic iteration with a fixed shift, registered
// depends on ate_pkg
module ate_cordic_cell
    import ate_pkg::*;
#(
    parameter int STEP = 0
)
(
    input  wire logic    clk,
    input  wire cordic_t cin,
    output cordic_t      cout
);

    cordic_t cell_reg;
    cordic_t cell_next;
    logic signed [XY_W-1:0]  xs;
    logic signed [XY_W-1:0]  ys;
    logic signed [ANG_W-1:0] da;

    always_comb
    begin
        xs = cin.x >>> STEP;
        ys = cin.y >>> STEP;
        da = $signed({1'b0, ATAN_TABLE[STEP]});
        if (!cin.y[XY_W-1] && (cin.y != '0))
        begin
            cell_next.x   = cin.x + ys;
            cell_next.y   = cin.y - xs;
            cell_next.ang = cin.ang + da;
        end
        else
        begin
            cell_next.x   = cin.x - ys;
            cell_next.y   = cin.y + xs;
            cell_next.ang = cin.ang - da;
        end
    end

    always_ff @(posedge clk)
    begin
        cell_reg <= cell_next;
    end

    assign cout = cell_reg;

endmodule
`default_nettype wire

[hw/rtl/ate_ema_lane.sv]
`timescale 1ns / 1ps
`default_nettype none
// one exponential moving average channel: difference, multiply, commit
// depends on ate_pkg
module ate_ema_lane
    import ate_pkg::*;
#(
    parameter int AVG_W = 32
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire ema_ctl_t                ctl,
    input  wire logic signed [AVG_W-17:0] sample,
    input  wire logic [16:0]             gain,
    output logic signed [AVG_W-17:0]     smooth
);

    logic signed [AVG_W-1:0]  avg_reg;
    logic signed [AVG_W-1:0]  avg_next;
    logic signed [AVG_W+1:0]  diff_reg;
    logic signed [AVG_W+1:0]  diff_next;
    logic signed [AVG_W+19:0] prod_reg;
    logic signed [AVG_W:0]    rnd;

    always_comb
    begin
        diff_next = $signed({{2{sample[AVG_W-17]}}, sample, 16'h0000})
                  - $signed({{2{avg_reg[AVG_W-1]}}, avg_reg});
        avg_next  = avg_reg + prod_reg[AVG_W+15:16];
        rnd       = $signed({avg_reg[AVG_W-1], avg_reg}) + (AVG_W+1)'(32768);
        smooth    = rnd[AVG_W-1:16];
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            diff_reg <= diff_next;
        end
        if (ctl.mul)
        begin
            prod_reg <= (AVG_W+20)'(diff_reg * $signed({1'b0, gain}));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg <= '0;
        end
        else if (ctl.commit && ctl.update)
        begin
            avg_reg <= avg_next;
        end
    end

endmodule
`default_nettype wire
